>>> design/wnpc_pkg.sv
// ----------------------------------------------------------------------------
// wnpc_pkg: shared types and codes of the palette color matcher
// Work item layout and kind codes passed from the front end to the search
// engine through the command queue.
// ----------------------------------------------------------------------------
package wnpc_pkg;

    localparam int CHAN_W   = 8;
    localparam int SIZE_W   = 9;
    localparam int KIND_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    // Kinds of work the back end carries out.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;  // write one palette entry
    localparam logic [KIND_W-1:0] KIND_PASS   = 2'd1;  // transparent pixel, copy through
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;  // opaque pixel, scan the palette

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last;
    } wnpc_item_t;

endpackage

>>> design/weighted_nearest_palette_color.sv
// ----------------------------------------------------------------------------
// weighted_nearest_palette_color: RGBA palettizer with weighted RGB distance
// Loads palette entries and maps opaque pixels to the index of the nearest
// entry under the cost 2*dr^2 + 4*dg^2 + 3*db^2.
// ----------------------------------------------------------------------------
//
//  Channel  Ports     Direction  Beat contents
//  -------  --------  ---------  ---------------------------------------------
//  input    s_*       in         command, entry index, RGBA, end of frame
//  result   m_*       out        index or color, alpha, last flag
//  config   cfg_*     in         palette_size (9 bits), always ready
//
// A load beat gives no result; a transparent pixel is copied through. An opaque
// pixel scans min(palette_size, PALETTE_DEPTH) entries, one entry per cycle
// through the single palette memory read port.
// Reset clears control state and palette_size; the palette memory is not cleared
// and holds no data until loaded, so no clearing pass runs after reset.
// The queue lets input beats be taken while a search runs or a result stalls.
//
module weighted_nearest_palette_color #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    // Input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_entry_index,
    input  logic [7:0] s_in_red,
    input  logic [7:0] s_in_green,
    input  logic [7:0] s_in_blue,
    input  logic [7:0] s_in_alpha,
    input  logic       s_end_of_frame,
    // Result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue,
    output logic [7:0] m_out_alpha,
    output logic       m_out_last
);
    import wnpc_pkg::*;

    // Work items travel from the classifier through the queue to the engine,
    // so loads and pixels are carried out in arrival order.
    wnpc_item_t push_item;
    wnpc_item_t pop_item;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;

    wnpc_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_entry_index  (s_entry_index),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .s_in_alpha     (s_in_alpha),
        .s_end_of_frame (s_end_of_frame),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    wnpc_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    // The engine owns the palette memory, the size register and the output
    // register that holds one result beat until the consumer takes it.
    wnpc_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha),
        .m_out_last  (m_out_last)
    );

endmodule

>>> design/wnpc_front.sv
// ----------------------------------------------------------------------------
// wnpc_front: input beat classifier
// Accepts input beats, sorts them into load, pass-through and search work,
// drops loads beyond the palette depth, and pushes work into the queue.
// ----------------------------------------------------------------------------
module wnpc_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [7:0]                s_entry_index,
    input  logic [7:0]                s_in_red,
    input  logic [7:0]                s_in_green,
    input  logic [7:0]                s_in_blue,
    input  logic [7:0]                s_in_alpha,
    input  logic                      s_end_of_frame,
    input  logic                      q_full,
    output logic                      q_push,
    output wnpc_pkg::wnpc_item_t      q_item
);
    import wnpc_pkg::*;

    logic in_range;

    assign s_ready  = !q_full;
    assign in_range = ({1'b0, s_entry_index} < SIZE_W'(PALETTE_DEPTH));

    // A load beyond the palette depth is accepted and discarded.
    assign q_push = s_valid && s_ready && !(s_command && !in_range);

    always_comb begin
        q_item.index = s_entry_index;
        q_item.red   = s_in_red;
        q_item.green = s_in_green;
        q_item.blue  = s_in_blue;
        q_item.alpha = s_in_alpha;
        q_item.last  = s_end_of_frame;
        if (s_command) begin
            q_item.kind = KIND_LOAD;
        end else if (s_in_alpha == '0) begin
            q_item.kind = KIND_PASS;
        end else begin
            q_item.kind = KIND_SEARCH;
        end
    end

endmodule

>>> design/wnpc_fifo.sv
// ----------------------------------------------------------------------------
// wnpc_fifo: command queue
// Small first-in first-out buffer of work items between front and back end.
// ----------------------------------------------------------------------------
module wnpc_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wnpc_pkg::wnpc_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output wnpc_pkg::wnpc_item_t  pop_item
);
    import wnpc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    wnpc_item_t     slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wptr_next  = do_push ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = do_pop  ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

>>> design/wnpc_back.sv
// ----------------------------------------------------------------------------
// wnpc_back: palette store and nearest color search engine
// Holds the palette memory and the size register, executes loads, and scans
// the palette one entry per cycle through a read, square and compare pipeline.
// ----------------------------------------------------------------------------
module wnpc_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [8:0]            cfg_data,
    input  logic                  q_valid,
    input  wnpc_pkg::wnpc_item_t  q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic [7:0]            m_out_alpha,
    output logic                  m_out_last
);
    import wnpc_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int LW = $clog2(PALETTE_DEPTH + 1);
    localparam int COST_W = 20;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [23:0]        mem [PALETTE_DEPTH];
    logic [SIZE_W-1:0]  size_reg;
    logic [LW-1:0]      limit;
    logic [1:0]         state_reg;
    logic [LW-1:0]      cnt_reg;

    logic [CHAN_W-1:0]  px_r_reg, px_g_reg, px_b_reg, px_a_reg;
    logic               px_last_reg;

    // Read stage
    logic               rd_valid_reg, rd_last_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [23:0]        rdata_reg;
    logic               rd_en, mem_we;
    logic [AW-1:0]      rd_addr;

    // Square stage
    logic               sq_valid_reg, sq_last_reg;
    logic [AW-1:0]      sq_idx_reg;
    logic [15:0]        sq_r_reg, sq_g_reg, sq_b_reg;
    logic [CHAN_W-1:0]  d_r, d_g, d_b;

    // Compare stage
    logic [COST_W-1:0]  cost, best_cost_reg;
    logic [AW-1:0]      best_idx_reg;
    logic               take;
    logic [AW-1:0]      win_idx;

    logic               out_valid_reg;
    logic [CHAN_W-1:0]  out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic               out_last_reg;

    logic               pop_ok;

    assign cfg_ready = 1'b1;
    assign limit = (size_reg > SIZE_W'(PALETTE_DEPTH)) ? LW'(PALETTE_DEPTH) : LW'(size_reg);

    // Loads never wait for the output slot; pixels need it free.
    assign pop_ok = (state_reg == ST_IDLE) && q_valid
                    && ((q_item.kind == KIND_LOAD) || !out_valid_reg);
    assign q_pop  = pop_ok;

    assign mem_we  = pop_ok && (q_item.kind == KIND_LOAD);
    assign rd_en   = (state_reg == ST_SCAN);
    assign rd_addr = cnt_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_item.index[AW-1:0]] <= {q_item.red, q_item.green, q_item.blue};
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign d_r = abs_diff(px_r_reg, rdata_reg[23:16]);
    assign d_g = abs_diff(px_g_reg, rdata_reg[15:8]);
    assign d_b = abs_diff(px_b_reg, rdata_reg[7:0]);

    assign cost = (COST_W'(sq_r_reg) << 1) + (COST_W'(sq_g_reg) << 2)
                + (COST_W'(sq_b_reg) << 1) + COST_W'(sq_b_reg);
    // The first entry always seeds the running best; ties keep the earlier one.
    assign take    = (sq_idx_reg == '0) || (cost < best_cost_reg);
    assign win_idx = take ? sq_idx_reg : best_idx_reg;

    always_ff @(posedge aclk) begin
        sq_r_reg <= 16'(d_r) * 16'(d_r);
        sq_g_reg <= 16'(d_g) * 16'(d_g);
        sq_b_reg <= 16'(d_b) * 16'(d_b);
        sq_idx_reg <= rd_idx_reg;
        sq_last_reg <= rd_last_reg;
        if (rd_en) begin
            rd_idx_reg  <= rd_addr;
            rd_last_reg <= (cnt_reg == limit - LW'(1));
        end
        if (sq_valid_reg && take) begin
            best_cost_reg <= cost;
            best_idx_reg  <= sq_idx_reg;
        end
        if (pop_ok) begin
            px_r_reg    <= q_item.red;
            px_g_reg    <= q_item.green;
            px_b_reg    <= q_item.blue;
            px_a_reg    <= q_item.alpha;
            px_last_reg <= q_item.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
            rd_valid_reg <= rd_en;
            sq_valid_reg <= rd_valid_reg;
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_ok && q_item.kind == KIND_PASS) begin
                        out_valid_reg <= 1'b1;
                        out_r_reg     <= q_item.red;
                        out_g_reg     <= q_item.green;
                        out_b_reg     <= q_item.blue;
                        out_a_reg     <= q_item.alpha;
                        out_last_reg  <= q_item.last;
                    end else if (pop_ok && q_item.kind == KIND_SEARCH) begin
                        if (limit == '0) begin
                            // Empty palette: index zero.
                            out_valid_reg <= 1'b1;
                            out_r_reg     <= '0;
                            out_g_reg     <= '0;
                            out_b_reg     <= '0;
                            out_a_reg     <= q_item.alpha;
                            out_last_reg  <= q_item.last;
                        end else begin
                            cnt_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + LW'(1);
                    if (cnt_reg == limit - LW'(1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (sq_valid_reg && sq_last_reg) begin
                        out_valid_reg <= 1'b1;
                        out_r_reg     <= CHAN_W'(win_idx);
                        out_g_reg     <= CHAN_W'(win_idx);
                        out_b_reg     <= CHAN_W'(win_idx);
                        out_a_reg     <= px_a_reg;
                        out_last_reg  <= px_last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = out_r_reg;
    assign m_out_green = out_g_reg;
    assign m_out_blue  = out_b_reg;
    assign m_out_alpha = out_a_reg;
    assign m_out_last  = out_last_reg;

    // A search only starts with the output slot free, and nothing fills it meanwhile.
    a_slot_free_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !out_valid_reg)
        else $error("output slot filled during a palette search");

    // Read data only follows a scan cycle.
    a_read_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(state_reg) == ST_SCAN)
        else $error("palette read outside a scan");

    // Back in idle, the pipeline holds no entry of the last search.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (!rd_valid_reg && !sq_valid_reg))
        else $error("search pipeline not drained in idle");

    // No work is taken from the queue while a search runs.
    a_no_pop_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !q_pop)
        else $error("queue popped during a search");

endmodule
